// ----- src/pofir_pkg.sv -----
// Shared constants, types and control structs for the power-of-two coefficient FIR.
package pofir_pkg;

	localparam int HISTORY_DEPTH = 256;
	localparam int MAX_STAGES    = 16;
	localparam int MAX_COEFFS    = 512;

	localparam int HIST_AW = $clog2(HISTORY_DEPTH);
	localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int STG_W   = $clog2(MAX_STAGES);
	localparam int SCNT_W  = $clog2(MAX_STAGES + 1);
	localparam int COEF_AW = $clog2(MAX_COEFFS);
	localparam int UCNT_W  = $clog2(MAX_COEFFS + 1);

	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 9;
	localparam int VAL_W      = 9;
	localparam int SAMPLE_W   = 16;
	localparam int OUT_W      = 41;
	localparam int ACC_W      = 42;
	localparam int TERM_SHIFT = 16;
	localparam int DLY_W      = 8;
	localparam int SIGN_POS   = 8;

	localparam int STAGE_CNT_W = 5;
	localparam int COEFF_CNT_W = 10;
	localparam int CFG_W       = 10;
	localparam int CFG_IDX_W   = 1;

	localparam logic [STAGE_CNT_W-1:0] STAGE_CNT_RST = STAGE_CNT_W'(16);
	localparam logic [COEFF_CNT_W-1:0] COEFF_CNT_RST = COEFF_CNT_W'(512);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_TERMS  = 2'd1,
		FUNC_COEFF  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STAGE_COUNT = 1'b0,
		CFG_COEFF_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STAGE,
		S_ISSUE,
		S_DRAIN,
		S_HALVE,
		S_FINISH
	} seq_state_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_CLEAR,
		ACC_ADD,
		ACC_SUB,
		ACC_HALVE
	} acc_op_t;

	typedef struct packed {
		acc_op_t op;
		logic    publish;
	} acc_ctl_t;

	typedef struct packed {
		logic               hist_we;
		logic [HIST_AW-1:0] hist_waddr;
		logic               hist_re;
		logic [HIST_AW-1:0] hist_raddr;
		logic               coef_we;
		logic [COEF_AW-1:0] coef_waddr;
		logic               coef_re;
		logic [COEF_AW-1:0] coef_raddr;
	} mem_ctl_t;

endpackage

// ----- src/pofir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pofir_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/pofir_acc.sv -----
// Shared accumulate unit: clear, add/subtract shifted term, halve, and result register.
module pofir_acc (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pofir_pkg::acc_ctl_t                  ctl,
	input  logic [pofir_pkg::SAMPLE_W-1:0]       hist_rdata,
	input  logic                                 result_ready,
	output logic                                 result_valid,
	output logic signed [pofir_pkg::OUT_W-1:0]   filtered,
	output logic                                 out_busy
);
	import pofir_pkg::*;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term;
	logic signed [OUT_W-1:0] filtered_q;
	logic                    result_valid_q;

	assign term = {{(ACC_W - SAMPLE_W - TERM_SHIFT){hist_rdata[SAMPLE_W-1]}},
		hist_rdata, {TERM_SHIFT{1'b0}}};

	always_ff @(posedge clk) begin
		case (ctl.op)
			ACC_CLEAR: acc_q <= '0;
			ACC_ADD:   acc_q <= acc_q + term;
			ACC_SUB:   acc_q <= acc_q - term;
			ACC_HALVE: acc_q <= acc_q >>> 1;
			default:   acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.publish) begin
			filtered_q <= acc_q[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.publish) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign filtered     = filtered_q;
	assign out_busy     = result_valid_q && !result_ready;

endmodule

// ----- src/pofir_seq.sv -----
// Sequencer: loads, history pointer, stage/coefficient walk and read pipeline control.
module pofir_seq (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  pofir_pkg::func_t                       func,
	input  logic [pofir_pkg::IDX_W-1:0]            load_index,
	input  logic [pofir_pkg::VAL_W-1:0]            load_value,
	input  logic [pofir_pkg::STAGE_CNT_W-1:0]      stage_count,
	input  logic [pofir_pkg::COEFF_CNT_W-1:0]      coeff_count,
	input  logic [pofir_pkg::VAL_W-1:0]            coef_rdata,
	input  logic                                   out_busy,
	output pofir_pkg::mem_ctl_t                    mem,
	output pofir_pkg::acc_ctl_t                    acc
);
	import pofir_pkg::*;

	seq_state_t state_q, state_d;

	logic [SCNT_W-1:0]  stage_q, stages_q;
	logic [UCNT_W-1:0]  used_q, limit_q;
	logic [VAL_W-1:0]   left_q;
	logic [HIST_AW-1:0] ptr_q, newest_q;
	logic [FILL_W-1:0]  fill_q;
	logic               v_s1_q, v_s2_q, sign_s2_q;
	logic [VAL_W-1:0]   stage_terms_q [MAX_STAGES];

	logic               accept, start, issue, hit;
	logic [DLY_W-1:0]   delay;
	logic [HIST_AW:0]   nd, dd, slot_w;
	logic [SCNT_W-1:0]  stages_sat;
	logic [UCNT_W-1:0]  limit_sat;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign start      = accept && (func == FUNC_SAMPLE);
	assign issue      = (state_q == S_ISSUE) && (left_q != '0) && (used_q < limit_q);

	assign stages_sat = (32'(stage_count) > MAX_STAGES) ? SCNT_W'(MAX_STAGES)
		: SCNT_W'(stage_count);
	assign limit_sat  = (32'(coeff_count) > MAX_COEFFS) ? UCNT_W'(MAX_COEFFS)
		: UCNT_W'(coeff_count);

	// s1: coefficient word arrives; a term is live only if its slot has been written
	assign delay  = coef_rdata[DLY_W-1:0];
	assign hit    = v_s1_q && (32'(delay) < 32'(fill_q));
	assign nd     = {1'b0, newest_q};
	assign dd     = (HIST_AW + 1)'(delay);
	assign slot_w = (nd >= dd) ? nd - dd : nd + (HIST_AW + 1)'(HISTORY_DEPTH) - dd;

	always_comb begin
		mem.hist_we    = start;
		mem.hist_waddr = ptr_q;
		mem.hist_re    = hit;
		mem.hist_raddr = slot_w[HIST_AW-1:0];
		mem.coef_we    = accept && (func == FUNC_COEFF) && (32'(load_index) < MAX_COEFFS);
		mem.coef_waddr = COEF_AW'(load_index);
		mem.coef_re    = issue;
		mem.coef_raddr = COEF_AW'(used_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		acc.op      = v_s2_q ? (sign_s2_q ? ACC_SUB : ACC_ADD) : ACC_HOLD;
		acc.publish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					acc.op  = ACC_CLEAR;
					state_d = S_STAGE;
				end
			end
			S_STAGE: begin
				state_d = (stage_q == stages_q) ? S_FINISH : S_ISSUE;
			end
			S_ISSUE: begin
				if (!issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!v_s1_q && !v_s2_q) begin
					state_d = S_HALVE;
				end
			end
			S_HALVE: begin
				acc.op  = ACC_HALVE;
				state_d = S_STAGE;
			end
			S_FINISH: begin
				if (!out_busy) begin
					acc.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			fill_q   <= '0;
			newest_q <= '0;
			stage_q  <= '0;
			stages_q <= '0;
			used_q   <= '0;
			limit_q  <= '0;
			left_q   <= '0;
			v_s1_q   <= 1'b0;
			v_s2_q   <= 1'b0;
		end else begin
			v_s1_q <= issue;
			v_s2_q <= hit;
			if (start) begin
				newest_q <= ptr_q;
				ptr_q    <= (ptr_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				if (fill_q != FILL_W'(HISTORY_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
				stage_q  <= '0;
				stages_q <= stages_sat;
				used_q   <= '0;
				limit_q  <= limit_sat;
			end
			if (state_q == S_STAGE && stage_q != stages_q) begin
				left_q <= stage_terms_q[stage_q[STG_W-1:0]];
			end
			if (issue) begin
				used_q <= used_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			if (state_q == S_HALVE) begin
				stage_q <= stage_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sign_s2_q <= coef_rdata[SIGN_POS];
		if (accept && func == FUNC_TERMS && 32'(load_index) < MAX_STAGES) begin
			stage_terms_q[STG_W'(load_index)] <= load_value;
		end
	end

`ifndef SYNTHESIS
	a_used_le_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> used_q <= limit_q)
		else $error("coefficient walk ran past its limit");

	a_halve_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HALVE |-> !v_s1_q && !v_s2_q)
		else $error("halve while terms still in flight");

	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> stage_q <= stages_q)
		else $error("stage index beyond stage count");

	a_no_busy_publish: assert property (@(posedge clk) disable iff (!arst_n)
		acc.publish |-> !out_busy && !v_s2_q)
		else $error("result published over a pending transaction or live term");
`endif

endmodule

// ----- src/power_of_two_coefficient_fir.sv -----
// Top level: signed power-of-two coefficient FIR with config registers and memories.
// Load transactions (func 1, 2, 3) complete in the accept cycle; no result is returned.
// A sample walks each stage through the stage, issue, drain and halve states, then publishes
// in finish after any wait on a result not yet taken; ready returns with result valid.
// Reset: stage_count 16, coeff_count 512; history reads as zero until written (fill count,
// no clearing pass); term counts and coefficients are undefined until loaded.
module power_of_two_coefficient_fir (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  logic [pofir_pkg::FUNC_W-1:0]           func,
	input  logic [pofir_pkg::IDX_W-1:0]            load_index,
	input  logic [pofir_pkg::VAL_W-1:0]            load_value,
	input  logic signed [pofir_pkg::SAMPLE_W-1:0]  sample,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic signed [pofir_pkg::OUT_W-1:0]     filtered,
	input  logic                                   cfg_we,
	input  logic [pofir_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pofir_pkg::CFG_W-1:0]            cfg_data
);
	import pofir_pkg::*;

	logic [STAGE_CNT_W-1:0] stage_count_q;
	logic [COEFF_CNT_W-1:0] coeff_count_q;
	mem_ctl_t               mem;
	acc_ctl_t               acc;
	logic [VAL_W-1:0]       coef_rdata;
	logic [SAMPLE_W-1:0]    hist_rdata;
	logic                   out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q <= STAGE_CNT_RST;
			coeff_count_q <= COEFF_CNT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STAGE_COUNT: stage_count_q <= cfg_data[STAGE_CNT_W-1:0];
				CFG_COEFF_COUNT: coeff_count_q <= cfg_data[COEFF_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	pofir_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.func        (func_t'(func)),
		.load_index  (load_index),
		.load_value  (load_value),
		.stage_count (stage_count_q),
		.coeff_count (coeff_count_q),
		.coef_rdata  (coef_rdata),
		.out_busy    (out_busy),
		.mem         (mem),
		.acc         (acc)
	);

	pofir_ram #(
		.DEPTH (MAX_COEFFS),
		.WIDTH (VAL_W)
	) u_coef_ram (
		.clk   (clk),
		.we    (mem.coef_we),
		.waddr (mem.coef_waddr),
		.wdata (load_value),
		.re    (mem.coef_re),
		.raddr (mem.coef_raddr),
		.rdata (coef_rdata)
	);

	pofir_ram #(
		.DEPTH (HISTORY_DEPTH),
		.WIDTH (SAMPLE_W)
	) u_hist_ram (
		.clk   (clk),
		.we    (mem.hist_we),
		.waddr (mem.hist_waddr),
		.wdata (sample),
		.re    (mem.hist_re),
		.raddr (mem.hist_raddr),
		.rdata (hist_rdata)
	);

	pofir_acc u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (acc),
		.hist_rdata   (hist_rdata),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.filtered     (filtered),
		.out_busy     (out_busy)
	);

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the power-of-two coefficient FIR: table loads, samples, configs.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pofir_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 700;

	// Keeps its own copy of the filter state and the expected outputs.
	class fir_scoreboard;
		logic signed [SAMPLE_W-1:0] history [HISTORY_DEPTH];
		logic [HIST_AW-1:0]         wr_ptr;
		logic [VAL_W-1:0]           terms [MAX_STAGES];
		logic [VAL_W-1:0]           coeffs [MAX_COEFFS];
		logic [STAGE_CNT_W-1:0]     stage_count;
		logic [COEFF_CNT_W-1:0]     coeff_count;
		logic signed [OUT_W-1:0]    expected_filtered [$];
		int                         errors;

		function new();
			foreach (history[i]) history[i] = '0;
			foreach (terms[i]) terms[i] = '0;
			foreach (coeffs[i]) coeffs[i] = '0;
			wr_ptr = '0;
			stage_count = STAGE_CNT_RST;
			coeff_count = COEFF_CNT_RST;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t which, logic [CFG_W-1:0] data);
			if (which == CFG_STAGE_COUNT) begin
				stage_count = data[STAGE_CNT_W-1:0];
			end else begin
				coeff_count = data[COEFF_CNT_W-1:0];
			end
		endfunction

		function logic signed [OUT_W-1:0] filter_output();
			longint              acc;
			longint              term;
			int                  used;
			int                  stages;
			int                  limit;
			logic [VAL_W-1:0]    c;
			logic [HIST_AW-1:0]  slot;
			acc = 0;
			used = 0;
			stages = (stage_count > MAX_STAGES) ? MAX_STAGES : stage_count;
			limit = (coeff_count > MAX_COEFFS) ? MAX_COEFFS : coeff_count;
			for (int j = 0; j < stages; j++) begin
				for (int k = 0; k < terms[j] && used < limit; k++) begin
					c = coeffs[used];
					used++;
					// newest sample sits one below the write pointer
					slot = wr_ptr - 8'd1 - c[DLY_W-1:0];
					term = longint'(history[slot]) <<< TERM_SHIFT;
					if (c[SIGN_POS]) begin
						acc -= term;
					end else begin
						acc += term;
					end
				end
				acc = acc >>> 1;
			end
			return acc[OUT_W-1:0];
		endfunction

		function void take_item(func_t f, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
				logic signed [SAMPLE_W-1:0] smp);
			case (f)
				FUNC_TERMS: begin
					if (idx < MAX_STAGES) terms[idx] = val;
				end
				FUNC_COEFF: begin
					if (idx < MAX_COEFFS) coeffs[idx] = val;
				end
				FUNC_SAMPLE: begin
					history[wr_ptr] = smp;
					wr_ptr++;
					expected_filtered.push_back(filter_output());
				end
				default: ;
			endcase
		endfunction

		function void check_filtered(logic signed [OUT_W-1:0] got);
			logic signed [OUT_W-1:0] exp_val;
			if (expected_filtered.size() == 0) begin
				$error("filtered: unexpected result %0d with nothing pending", got);
				errors++;
			end else begin
				exp_val = expected_filtered.pop_front();
				if (got !== exp_val) begin
					$error("filtered mismatch: expected %0d, actual %0d", exp_val, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       item_valid = 1'b0;
	logic                       item_ready;
	logic [FUNC_W-1:0]          func = FUNC_NONE;
	logic [IDX_W-1:0]           load_index = '0;
	logic [VAL_W-1:0]           load_value = '0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       result_valid;
	logic                       result_ready = 1'b0;
	logic signed [OUT_W-1:0]    filtered;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = CFG_STAGE_COUNT;
	logic [CFG_W-1:0]           cfg_data = '0;

	fir_scoreboard sb = new();

	bit  calm = 1'b0;
	int  hold_asked = 0;
	int  hold_done = 0;
	int  hold_left = 0;
	longint cycle_count = 0;
	int  samples_sent = 0;
	int  loads_sent = 0;
	int  ignored_sent = 0;
	int  settings_used = 0;
	bit  terms_loaded [MAX_STAGES];
	bit  coeff_loaded [MAX_COEFFS];

	power_of_two_coefficient_fir uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.func         (func),
		.load_index   (load_index),
		.load_value   (load_value),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.filtered     (filtered),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_filtered(filtered);
	end

	// Result side: random back-pressure, plus long hold-offs on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else if (hold_asked != hold_done) begin
				result_ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				hold_done++;
			end else begin
				result_ready <= calm || ($urandom_range(99) >= 22);
			end
		end
	end

	function automatic logic [VAL_W-1:0] rand_terms();
		if ($urandom_range(24) == 0) return VAL_W'($urandom_range(511));
		return VAL_W'($urandom_range(6));
	endfunction

	function automatic logic [VAL_W-1:0] rand_coeff();
		logic [DLY_W-1:0] dly;
		dly = $urandom_range(1) ? DLY_W'($urandom_range(15)) : DLY_W'($urandom_range(255));
		return {1'($urandom_range(1)), dly};
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(15))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_item(func_t f, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
			logic signed [SAMPLE_W-1:0] smp);
		int gap;
		gap = 0;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 22) gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		func <= f;
		load_index <= idx;
		load_value <= val;
		sample <= smp;
		do @(posedge clk); while (!item_ready);
		sb.take_item(f, idx, val, smp);
		case (f)
			FUNC_SAMPLE: samples_sent++;
			FUNC_TERMS: begin
				if (idx < MAX_STAGES) begin
					terms_loaded[idx] = 1'b1;
					loads_sent++;
				end else begin
					ignored_sent++;
				end
			end
			FUNC_COEFF: begin
				coeff_loaded[idx] = 1'b1;
				loads_sent++;
			end
			default: ignored_sent++;
		endcase
	endtask

	task automatic idle_input();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// Block is idle once every result is back; loads finish in their accept cycle.
	task automatic wait_quiet();
		idle_input();
		while (sb.expected_filtered.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t which, logic [CFG_W-1:0] data);
		wait_quiet();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= data;
		sb.set_reg(which, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_filter(int stages, int coeff_total);
		write_reg(CFG_STAGE_COUNT, CFG_W'(stages));
		write_reg(CFG_COEFF_COUNT, CFG_W'(coeff_total));
		settings_used++;
	endtask

	// Never let a sample read a term count or coefficient that was not loaded.
	task automatic fill_tables();
		int stages;
		int limit;
		int needed;
		stages = (sb.stage_count > MAX_STAGES) ? MAX_STAGES : sb.stage_count;
		limit = (sb.coeff_count > MAX_COEFFS) ? MAX_COEFFS : sb.coeff_count;
		for (int j = 0; j < stages; j++) begin
			if (!terms_loaded[j]) send_item(FUNC_TERMS, IDX_W'(j), rand_terms(), SAMPLE_W'($urandom));
		end
		needed = 0;
		for (int j = 0; j < stages; j++) needed += sb.terms[j];
		if (needed > limit) needed = limit;
		for (int s = 0; s < needed; s++) begin
			if (!coeff_loaded[s]) send_item(FUNC_COEFF, IDX_W'(s), rand_coeff(), SAMPLE_W'($urandom));
		end
	endtask

	task automatic send_sample(logic signed [SAMPLE_W-1:0] smp);
		fill_tables();
		send_item(FUNC_SAMPLE, IDX_W'($urandom), VAL_W'($urandom), smp);
	endtask

	task automatic random_item();
		int r;
		logic [IDX_W-1:0] idx;
		r = $urandom_range(99);
		if (r < 58) begin
			send_sample(rand_sample());
		end else if (r < 73) begin
			idx = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(511, MAX_STAGES))
				: IDX_W'($urandom_range(MAX_STAGES - 1));
			send_item(FUNC_TERMS, idx, rand_terms(), SAMPLE_W'($urandom));
		end else if (r < 94) begin
			idx = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(511)) : IDX_W'($urandom_range(31));
			send_item(FUNC_COEFF, idx, rand_coeff(), SAMPLE_W'($urandom));
		end else begin
			send_item(FUNC_NONE, IDX_W'($urandom), VAL_W'($urandom), SAMPLE_W'($urandom));
		end
	endtask

	task automatic run_random(int sample_total);
		int start;
		start = samples_sent;
		while (samples_sent - start < sample_total) random_item();
	endtask

	task automatic preload_long_stages();
		for (int j = 0; j < MAX_STAGES; j++) send_item(FUNC_TERMS, IDX_W'(j), 9'd33, SAMPLE_W'($urandom));
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: two short stages, eight coefficients
		set_filter(2, 8);
		send_item(FUNC_TERMS, 9'd0, 9'd3, 16'sh0000);
		send_item(FUNC_TERMS, 9'd1, 9'd2, 16'sh7fff);
		send_item(FUNC_TERMS, 9'd16, 9'd7, 16'sh0000);
		send_item(FUNC_TERMS, 9'd511, 9'd511, 16'shffff);
		send_item(FUNC_COEFF, 9'd0, 9'h000, 16'sh0000);
		send_item(FUNC_COEFF, 9'd1, 9'h101, 16'sh0000);
		send_item(FUNC_COEFF, 9'd2, 9'h0ff, 16'sh0000);
		send_item(FUNC_COEFF, 9'd3, 9'h1ff, 16'sh0000);
		send_item(FUNC_COEFF, 9'd4, 9'h002, 16'sh0000);
		send_item(FUNC_NONE, 9'h1ff, 9'h1ff, 16'shffff);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'shffff);
		send_sample(16'sh0000);
		send_sample(16'sh0001);
		send_sample(16'sh5555);
		// term count of all ones runs into the coefficient limit
		send_item(FUNC_TERMS, 9'd1, 9'd511, 16'sh0000);
		send_item(FUNC_COEFF, 9'd7, 9'h1aa, 16'sh0000);
		send_sample(16'sh8000);
		send_sample(16'sh2aaa);

		set_filter(3, 40);
		run_random(5);

		// every stage and every coefficient in use
		set_filter(16, 512);
		preload_long_stages();
		run_random(3);

		set_filter(4, 24);
		calm = 1'b1;
		run_random(8);
		calm = 1'b0;

		set_filter(0, 5);
		run_random(2);

		// both counts above their maxima saturate
		set_filter(31, 1023);
		preload_long_stages();
		run_random(3);

		set_filter(1, 0);
		run_random(2);

		set_filter(5, 100);
		run_random(2);
		hold_asked++;
		run_random(4);
		wait_quiet();
		run_random(2);

		set_filter(16, 1);
		run_random(2);

		set_filter(2, 12);
		run_random(4);

		wait_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.errors += sb.expected_filtered.size();

		$display("tb: %0d samples filtered, %0d table loads, %0d ignored transactions",
			samples_sent, loads_sent, ignored_sent);
		$display("tb: %0d filter settings, %0d cycles", settings_used, cycle_count);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
